[src/clws_pkg.sv]
// ----------------------------------------------------------------------------
// clws_pkg
// Widths, register indexes and fixed-point constants shared by the cascaded
// linear-weight smoother, its channel interfaces and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package clws_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int WEIGHT_W   = 20;
   localparam int RATE_W     = 18;
   localparam int STAGES_W   = 4;
   localparam int TAPS_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   // Q16 arithmetic
   localparam int Q16_ONE  = 65536;
   localparam int Q16_HALF = 32768;
   localparam int Q16_SHIFT = 16;
   localparam int INV_W    = 17;
   localparam int DIV_W    = 20;

   localparam int SAMPLE_MAX = 32767;
   localparam int SAMPLE_MIN = -32768;
   localparam int WEIGHT_MAX = 524287;
   localparam int WEIGHT_MIN = -524288;

   localparam logic [STAGES_W-1:0] STAGES_RST = STAGES_W'(1);
   localparam logic [TAPS_W-1:0]   TAPS_RST   = TAPS_W'(2);
   localparam logic [RATE_W-1:0]   RATE_RST   = RATE_W'(32768);
   localparam logic [SAMPLE_W-1:0] LEVEL_RST  = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STAGES = 2'd0,
      CSR_TAPS   = 2'd1,
      CSR_RATE   = 2'd2,
      CSR_LEVEL  = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

[src/clws_if.sv]
// ----------------------------------------------------------------------------
// clws channel interfaces
// Valid/ready channels for samples, smoothed results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface clws_sample_if import clws_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface clws_smooth_if import clws_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] smoothed;

   modport source (output valid, output smoothed, input ready);
   modport sink   (input valid, input smoothed, output ready);
endinterface

interface clws_csr_if import clws_pkg::*;;
   logic                    valid;
   logic                    ready;
   csr_index_type           index;
   logic [CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[src/cascaded_linear_weight_smoother.sv]
// ----------------------------------------------------------------------------
// cascaded_linear_weight_smoother
// Cascade of recursive linear-weight smoothing stages sharing one MAC unit.
// A sample beat is taken only while idle, so no new sample is accepted
//   until the last one has passed the single MAC unit over every active tap
//   of every active stage (line memory port) and its result is registered.
// Reset and every register write run a rebuild (two serial divides, then a
//   one-entry-per-cycle line refill); no sample beat is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_linear_weight_smoother import clws_pkg::*; #(
   parameter int MAX_STAGES = 8,
   parameter int MAX_TAPS   = 16
) (
   input  logic          clock,
   input  logic          reset,
   clws_csr_if.sink      csr_bus,
   clws_sample_if.sink   req_bus,
   clws_smooth_if.source rsp_bus
);

   localparam int DEPTH  = MAX_STAGES * MAX_TAPS;
   localparam int AW     = $clog2(DEPTH);
   localparam int TW     = $clog2(MAX_TAPS);
   localparam int NTW    = $clog2(MAX_TAPS + 1);
   localparam int SCW    = $clog2(MAX_STAGES + 1);
   localparam int FCW    = AW + 1;
   localparam int DCW    = $clog2(DIV_W + 1);
   localparam int PROD_W = SAMPLE_W + WEIGHT_W;
   localparam int ACC_W  = PROD_W + TW + 1;
   localparam int WRUN_W = WEIGHT_W + TW + 3;
   localparam int STEP_W = DIV_W + 1;
   localparam int RND_W  = ACC_W - Q16_SHIFT;

   localparam logic signed [WRUN_W-1:0] W_HI = WRUN_W'(WEIGHT_MAX);
   localparam logic signed [WRUN_W-1:0] W_LO = WRUN_W'(WEIGHT_MIN);
   localparam logic signed [RND_W-1:0]  S_HI = RND_W'(SAMPLE_MAX);
   localparam logic signed [RND_W-1:0]  S_LO = RND_W'(SAMPLE_MIN);

   typedef enum logic [2:0] {
      ST_PREP, ST_INV, ST_STEP, ST_FILL, ST_IDLE, ST_TERM, ST_DRAIN, ST_DONE
   } state_type;

   // memories
   logic signed [SAMPLE_W-1:0] line_mem [DEPTH];
   logic signed [WEIGHT_W-1:0] wt_mem   [MAX_TAPS];

   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic signed [SAMPLE_W-1:0] mem_wdata;
   logic [AW-1:0]              mem_raddr;
   logic signed [SAMPLE_W-1:0] mem_rdata_ff;
   logic                       wt_we;
   logic [TW-1:0]              wt_waddr;
   logic signed [WEIGHT_W-1:0] wt_wdata;
   logic [TW-1:0]              wt_raddr;
   logic signed [WEIGHT_W-1:0] wt_rdata_ff;

   // control and config
   state_type                  state_ff;
   logic [STAGES_W-1:0]        stages_ff;
   logic [TAPS_W-1:0]          taps_ff;
   logic signed [RATE_W-1:0]   rate_ff;
   logic signed [SAMPLE_W-1:0] level_ff;
   logic [SCW-1:0]             ns;
   logic [NTW-1:0]             nt;

   // divider
   logic [DIV_W-1:0]           div_num_ff;
   logic [DIV_W-1:0]           div_num_in;
   logic [NTW-1:0]             div_rem_ff;
   logic [NTW-1:0]             div_rem_in;
   logic [NTW-1:0]             div_den_ff;
   logic [DCW-1:0]             div_cnt_ff;
   logic [NTW:0]               div_shift;
   logic                       div_ge;
   logic                       div_last;

   logic signed [RATE_W:0]     step_diff;
   logic signed [RATE_W+1:0]   step_num;
   logic [DIV_W-1:0]           step_mag;
   logic                       neg_ff;
   logic signed [STEP_W-1:0]   step_in;
   logic signed [STEP_W-1:0]   step_ff;
   logic signed [WRUN_W-1:0]   w_run_ff;
   logic [FCW-1:0]             fill_cnt_ff;
   logic                       fill_wt;

   // MAC path
   logic [SCW-1:0]             stage_ff;
   logic [AW-1:0]              base_ff;
   logic [TW-1:0]              tap_ff;
   logic                       b_vld_ff;
   logic [TW-1:0]              b_idx_ff;
   logic                       c_vld_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] mac_op;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_rnd;
   logic signed [RND_W-1:0]    acc_q;
   logic signed [SAMPLE_W-1:0] q_sat;
   logic                       stage_fin;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   assign csr_bus.ready    = 1'b1;
   assign req_bus.ready    = (state_ff == ST_IDLE) && !csr_bus.valid;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.smoothed = rsp_data_ff;

   always_comb begin
      if (stages_ff == '0) begin
         ns = SCW'(1);
      end else if (32'(stages_ff) > MAX_STAGES) begin
         ns = SCW'(MAX_STAGES);
      end else begin
         ns = SCW'(stages_ff);
      end
      if (taps_ff < TAPS_W'(2)) begin
         nt = NTW'(2);
      end else if (32'(taps_ff) > MAX_TAPS) begin
         nt = NTW'(MAX_TAPS);
      end else begin
         nt = NTW'(taps_ff);
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      div_shift  = {div_rem_ff, div_num_ff[DIV_W-1]};
      div_ge     = (div_shift >= {1'b0, div_den_ff});
      div_rem_in = div_ge ? NTW'(div_shift - {1'b0, div_den_ff}) : NTW'(div_shift);
      div_num_in = {div_num_ff[DIV_W-2:0], div_ge};
      div_last   = (div_cnt_ff == DCW'(DIV_W - 1));
   end

   // step numerator from inverse of tap count
   always_comb begin
      step_diff = (RATE_W+1)'(rate_ff) - (RATE_W+1)'(div_num_in[INV_W-1:0]);
      step_num  = {step_diff, 1'b0};
      step_mag  = step_num[RATE_W+1] ? DIV_W'(-step_num) : DIV_W'(step_num);
      step_in   = neg_ff ? -STEP_W'({1'b0, div_num_in}) : STEP_W'({1'b0, div_num_in});
   end

   always_comb begin
      acc_rnd   = acc_ff + ACC_W'(Q16_HALF);
      acc_q     = RND_W'(acc_rnd >>> Q16_SHIFT);
      if (acc_q > S_HI) begin
         q_sat = SAMPLE_W'(SAMPLE_MAX);
      end else if (acc_q < S_LO) begin
         q_sat = SAMPLE_W'(SAMPLE_MIN);
      end else begin
         q_sat = SAMPLE_W'(acc_q);
      end
      stage_fin = (state_ff == ST_DRAIN) && !b_vld_ff && !c_vld_ff;
      mac_op    = (b_idx_ff == '0) ? x_ff : mem_rdata_ff;
      fill_wt   = (fill_cnt_ff < FCW'(MAX_TAPS));
   end

   // memory ports
   always_comb begin
      mem_raddr = base_ff + AW'(tap_ff) - AW'(1);
      wt_raddr  = tap_ff;
      mem_we    = 1'b0;
      mem_waddr = base_ff;
      mem_wdata = q_sat;
      priority if (state_ff == ST_FILL) begin
         mem_we    = 1'b1;
         mem_waddr = fill_cnt_ff[AW-1:0];
         mem_wdata = level_ff;
      end else if (b_vld_ff && (b_idx_ff != '0)) begin
         mem_we    = 1'b1;
         mem_waddr = base_ff + AW'(b_idx_ff);
         mem_wdata = mem_rdata_ff;
      end else if (stage_fin) begin
         mem_we    = 1'b1;
      end else begin
         mem_we    = 1'b0;
      end
      wt_we    = (state_ff == ST_FILL) && fill_wt;
      wt_waddr = fill_cnt_ff[TW-1:0];
      if (w_run_ff > W_HI) begin
         wt_wdata = WEIGHT_W'(WEIGHT_MAX);
      end else if (w_run_ff < W_LO) begin
         wt_wdata = WEIGHT_W'(WEIGHT_MIN);
      end else begin
         wt_wdata = WEIGHT_W'(w_run_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= line_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (wt_we) begin
         wt_mem[wt_waddr] <= wt_wdata;
      end
      wt_rdata_ff <= wt_mem[wt_raddr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PREP;
         stages_ff    <= STAGES_RST;
         taps_ff      <= TAPS_RST;
         rate_ff      <= RATE_RST;
         level_ff     <= LEVEL_RST;
         rsp_valid_ff <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
      end else begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= b_vld_ff;
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (b_vld_ff) begin
            prod_ff <= mac_op * wt_rdata_ff;
         end
         if (c_vld_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end

         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_STAGES: stages_ff <= csr_bus.data[STAGES_W-1:0];
               CSR_TAPS:   taps_ff   <= csr_bus.data[TAPS_W-1:0];
               CSR_RATE:   rate_ff   <= csr_bus.data[RATE_W-1:0];
               CSR_LEVEL:  level_ff  <= csr_bus.data[SAMPLE_W-1:0];
               default:    ;
            endcase
            state_ff <= ST_PREP;
         end else begin
            unique case (state_ff)
               ST_PREP: begin
                  div_num_ff <= DIV_W'(Q16_ONE) + DIV_W'(nt >> 1);
                  div_den_ff <= nt;
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= ST_INV;
               end
               ST_INV: begin
                  div_cnt_ff <= div_cnt_ff + DCW'(1);
                  div_num_ff <= div_num_in;
                  div_rem_ff <= div_rem_in;
                  if (div_last) begin
                     div_num_ff <= step_mag + DIV_W'((nt - NTW'(1)) >> 1);
                     div_den_ff <= nt - NTW'(1);
                     div_rem_ff <= '0;
                     div_cnt_ff <= '0;
                     neg_ff     <= step_num[RATE_W+1];
                     state_ff   <= ST_STEP;
                  end
               end
               ST_STEP: begin
                  div_cnt_ff <= div_cnt_ff + DCW'(1);
                  div_num_ff <= div_num_in;
                  div_rem_ff <= div_rem_in;
                  if (div_last) begin
                     step_ff     <= step_in;
                     w_run_ff    <= WRUN_W'(rate_ff);
                     fill_cnt_ff <= '0;
                     state_ff    <= ST_FILL;
                  end
               end
               ST_FILL: begin
                  fill_cnt_ff <= fill_cnt_ff + FCW'(1);
                  if (fill_wt) begin
                     w_run_ff <= w_run_ff - WRUN_W'(step_ff);
                  end
                  if (fill_cnt_ff == FCW'(DEPTH - 1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
               ST_IDLE: begin
                  if (req_bus.valid) begin
                     x_ff     <= req_bus.sample;
                     stage_ff <= '0;
                     base_ff  <= '0;
                     tap_ff   <= TW'(nt - NTW'(1));
                     acc_ff   <= '0;
                     state_ff <= ST_TERM;
                  end
               end
               ST_TERM: begin
                  b_vld_ff <= 1'b1;
                  b_idx_ff <= tap_ff;
                  if (tap_ff == '0) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     tap_ff <= tap_ff - TW'(1);
                  end
               end
               ST_DRAIN: begin
                  if (stage_fin) begin
                     x_ff <= q_sat;
                     if (SCW'(stage_ff + SCW'(1)) == ns) begin
                        state_ff <= ST_DONE;
                     end else begin
                        stage_ff <= stage_ff + SCW'(1);
                        base_ff  <= base_ff + AW'(MAX_TAPS);
                        tap_ff   <= TW'(nt - NTW'(1));
                        acc_ff   <= '0;
                        state_ff <= ST_TERM;
                     end
                  end
               end
               ST_DONE: begin
                  if (!rsp_valid_ff || rsp_bus.ready) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_data_ff  <= x_ff;
                     state_ff     <= ST_IDLE;
                  end
               end
               default: state_ff <= ST_PREP;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

[src/clws_checker.sv]
// ----------------------------------------------------------------------------
// clws_checker
// Port-level checks for the cascaded linear-weight smoother, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module clws_checker import clws_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_smoothed,
   input logic                csr_valid,
   input logic                csr_ready
);

   logic [1:0] open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
      end
   end

   // a waiting result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smoothed))
      else $error("result beat dropped or changed while stalled");

   // no result without a sample that owes one
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("result beat without an open sample");

   // one sample in work plus one waiting result at most
   a_open_max: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("too many samples open");

   // sample beat starts work, the next one waits
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while busy");

   // register write starts a rebuild
   a_busy_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_ready)
      else $error("sample port open during rebuild");

endmodule

bind cascaded_linear_weight_smoother clws_checker u_clws_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_smoothed (rsp_bus.smoothed),
   .csr_valid    (csr_bus.valid),
   .csr_ready    (csr_bus.ready)
);

`default_nettype wire
